[hdl/uart_frame_crc8_receiver_macros.svh]
// ============================================================================
// uart_frame_crc8_receiver_macros - assertion helpers
// Shared concurrent assertion macros for the serial frame receiver.
// ============================================================================
`ifndef UART_FRAME_CRC8_RECEIVER_MACROS_SVH
`define UART_FRAME_CRC8_RECEIVER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define UCRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ucrc assertion failed");

// next-cycle implication, disabled while in reset
`define UCRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ucrc assertion failed");

// invariant that holds on every edge out of reset
`define UCRC_ASSERT_ALW(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ucrc assertion failed");

`endif

[hdl/ucrc_pkg.sv]
// ============================================================================
// ucrc_pkg - serial frame receiver package
// Types, constants and the CRC-8 byte update shared by the receiver modules.
// ============================================================================
package ucrc_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int PAYLOAD_W     = 64;
    localparam int LANE_W        = 3;
    localparam int POS_W         = 4;

    localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
    localparam logic [POS_W-1:0] POS_LEN  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_PAY0 = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CRC  = POS_W'(PAYLOAD_BYTES + 2);
    localparam logic [POS_W-1:0] POS_TAIL = POS_W'(PAYLOAD_BYTES + 3);

    localparam logic [7:0] LEN_BYTE = 8'(PAYLOAD_BYTES);
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'h00;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TAIL    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(2);

    localparam logic [7:0]  HEADER_RST  = 8'hA5;
    localparam logic [7:0]  TAIL_RST    = 8'h5A;
    localparam logic [15:0] TIMEOUT_RST = 16'd100;
    localparam logic [15:0] AGE_MAX     = 16'hFFFF;

    // two-entry queues on both sides of the parser
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic       hdr_hit;
        logic       len_hit;
        logic       tail_hit;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic                 frame_ok;
        logic [PAYLOAD_W-1:0] payload;
        logic                 online;
    } result_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[hdl/uart_frame_crc8_receiver.sv]
// ============================================================================
// uart_frame_crc8_receiver - serial frame receiver with CRC-8 check
// Header/length/payload/CRC/tail frame parser with link-online status.
// ============================================================================
// Path: an item waits in the intake queue, the parser runs on it from there, and
//   its result is loaded into the result queue that drives the result ports.
// Throughput: one item per cycle while the result queue has room or is popped;
//   the parser and its unrolled CRC-8 byte update are combinational; two-entry queues sit either side.
// Reset: rst_n clears parser, age and both queues at once and loads the marker
//   and timeout registers with their defaults; no clearing pass follows.

module uart_frame_crc8_receiver (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // item intake
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 op,
    input  logic [7:0]                           rx_byte,
    // results
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 frame_ok,
    output logic [63:0]                          payload,
    output logic                                 online,
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [ucrc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ucrc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // configuration registers
    logic [7:0]     header_reg, header_next;
    logic [7:0]     tail_reg, tail_next;
    logic [15:0]    timeout_reg, timeout_next;

    // front-to-back link
    logic               cmd_valid;
    logic               cmd_take;
    ucrc_pkg::cmd_t     cmd;
    ucrc_pkg::result_t  res;

    // register write decode; an index beyond the list is dropped
    always_comb
    begin
        header_next  = header_reg;
        tail_next    = tail_reg;
        timeout_next = timeout_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ucrc_pkg::REG_HEADER:  header_next  = cfg_data[7:0];
                ucrc_pkg::REG_TAIL:    tail_next    = cfg_data[7:0];
                ucrc_pkg::REG_TIMEOUT: timeout_next = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= ucrc_pkg::HEADER_RST;
            tail_reg    <= ucrc_pkg::TAIL_RST;
            timeout_reg <= ucrc_pkg::TIMEOUT_RST;
        end
        else
        begin
            header_reg  <= header_next;
            tail_reg    <= tail_next;
            timeout_reg <= timeout_next;
        end
    end

    // front: takes items, tags bytes with header/length/tail matches
    ucrc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .rx_byte     (rx_byte),
        .header_byte (header_reg),
        .tail_byte   (tail_reg),
        .cmd_valid   (cmd_valid),
        .cmd_take    (cmd_take),
        .cmd         (cmd)
    );

    // back: frame parser, CRC compare, age counter and result queue
    ucrc_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd_valid          (cmd_valid),
        .cmd_take           (cmd_take),
        .cmd                (cmd),
        .offline_timeout_ms (timeout_reg),
        .empty              (empty),
        .pop                (pop),
        .res                (res)
    );

    assign frame_ok = res.frame_ok;
    assign payload  = res.payload;
    assign online   = res.online;

endmodule

[hdl/ucrc_front.sv]
// ============================================================================
// ucrc_front - item intake and classification
// Tags each accepted item with its kind and marker matches, queues it.
// ============================================================================
`include "uart_frame_crc8_receiver_macros.svh"

module ucrc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 op,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           header_byte,
    input  logic [7:0]           tail_byte,
    output logic                 cmd_valid,
    input  logic                 cmd_take,
    output ucrc_pkg::cmd_t       cmd
);

    ucrc_pkg::cmd_t                       q_mem_reg [ucrc_pkg::QUEUE_DEPTH];
    logic [ucrc_pkg::QUEUE_AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [ucrc_pkg::QUEUE_AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [ucrc_pkg::QUEUE_CW-1:0]        count_reg, count_next;
    ucrc_pkg::cmd_t                       cls;
    logic                                 wr_en, rd_en;

    // classify on markers; the user changes them only while idle, not enforced
    always_comb
    begin
        cls.kind     = op ? ucrc_pkg::CMD_TICK : ucrc_pkg::CMD_BYTE;
        cls.hdr_hit  = (rx_byte == header_byte);
        cls.len_hit  = (rx_byte == ucrc_pkg::LEN_BYTE);
        cls.tail_hit = (rx_byte == tail_byte);
        cls.data     = rx_byte;
    end

    assign full      = (count_reg == ucrc_pkg::QUEUE_CW'(ucrc_pkg::QUEUE_DEPTH));
    assign wr_en     = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign rd_en     = cmd_take && cmd_valid;
    assign cmd       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == ucrc_pkg::QUEUE_AW'(ucrc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == ucrc_pkg::QUEUE_AW'(ucrc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

    `UCRC_ASSERT_ALW(a_front_count_bound, clk, rst_n,
        count_reg <= ucrc_pkg::QUEUE_CW'(ucrc_pkg::QUEUE_DEPTH))

endmodule

[hdl/ucrc_back.sv]
// ============================================================================
// ucrc_back - frame parser, CRC check and link age
// Runs queued items through the parser and queues one result per item.
// ============================================================================
`include "uart_frame_crc8_receiver_macros.svh"

module ucrc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_take,
    input  ucrc_pkg::cmd_t       cmd,
    input  logic [15:0]          offline_timeout_ms,
    output logic                 empty,
    input  logic                 pop,
    output ucrc_pkg::result_t    res
);

    logic [ucrc_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [7:0]                     crc_reg, crc_next;
    logic [7:0]                     rcrc_reg, rcrc_next;
    logic [ucrc_pkg::PAYLOAD_W-1:0] pay_reg, pay_next;
    logic                           ever_reg, ever_next;
    logic [15:0]                    age_reg, age_next;

    ucrc_pkg::result_t              rq_mem_reg [ucrc_pkg::QUEUE_DEPTH];
    logic [ucrc_pkg::QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [ucrc_pkg::QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [ucrc_pkg::QUEUE_CW-1:0]  count_reg, count_next;

    logic                           proc, rd_en, good;
    logic [ucrc_pkg::LANE_W-1:0]    lane;
    ucrc_pkg::result_t              res_new;

    assign empty = (count_reg == '0);
    assign rd_en = pop && !empty;
    // a slot is free now, or the head leaves this cycle
    assign proc     = cmd_valid &&
                      ((count_reg != ucrc_pkg::QUEUE_CW'(ucrc_pkg::QUEUE_DEPTH)) || rd_en);
    assign cmd_take = proc;
    assign res      = rq_mem_reg[rd_ptr_reg];
    assign lane     = ucrc_pkg::LANE_W'(pos_reg - ucrc_pkg::POS_PAY0);
    assign good     = cmd.tail_hit && (rcrc_reg == crc_reg);

    // parser and age update
    always_comb
    begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        rcrc_next = rcrc_reg;
        pay_next  = pay_reg;
        ever_next = ever_reg;
        age_next  = age_reg;
        res_new.frame_ok = 1'b0;
        res_new.payload  = '0;
        if (cmd.kind == ucrc_pkg::CMD_TICK)
        begin
            if (age_reg != ucrc_pkg::AGE_MAX)
            begin
                age_next = age_reg + 1'b1;
            end
        end
        else if (pos_reg == ucrc_pkg::POS_HUNT)
        begin
            if (cmd.hdr_hit)
            begin
                pos_next  = ucrc_pkg::POS_LEN;
                crc_next  = ucrc_pkg::CRC_INIT;
                rcrc_next = '0;
                pay_next  = '0;
            end
        end
        else if (pos_reg == ucrc_pkg::POS_LEN)
        begin
            // length wins over a repeated header of the same value
            if (cmd.len_hit)
            begin
                pos_next = ucrc_pkg::POS_PAY0;
            end
            else if (cmd.hdr_hit)
            begin
                pos_next  = ucrc_pkg::POS_LEN;
                crc_next  = ucrc_pkg::CRC_INIT;
                rcrc_next = '0;
                pay_next  = '0;
            end
            else
            begin
                pos_next = ucrc_pkg::POS_HUNT;
            end
        end
        else if (pos_reg < ucrc_pkg::POS_CRC)
        begin
            pay_next[lane*8 +: 8] = pay_reg[lane*8 +: 8] | cmd.data;
            crc_next = ucrc_pkg::crc8_byte(crc_reg, cmd.data);
            pos_next = pos_reg + 1'b1;
        end
        else if (pos_reg == ucrc_pkg::POS_CRC)
        begin
            rcrc_next = cmd.data;
            pos_next  = pos_reg + 1'b1;
        end
        else
        begin
            if (good)
            begin
                res_new.frame_ok = 1'b1;
                res_new.payload  = pay_reg;
                ever_next        = 1'b1;
                age_next         = '0;
            end
            pos_next = ucrc_pkg::POS_HUNT;
        end
        res_new.online = ever_next && (age_next <= offline_timeout_ms);
    end

    // result queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (proc)
        begin
            wr_ptr_next = (wr_ptr_reg == ucrc_pkg::QUEUE_AW'(ucrc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == ucrc_pkg::QUEUE_AW'(ucrc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (proc && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !proc)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= ucrc_pkg::POS_HUNT;
            crc_reg    <= ucrc_pkg::CRC_INIT;
            rcrc_reg   <= '0;
            pay_reg    <= '0;
            ever_reg   <= 1'b0;
            age_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (proc)
            begin
                pos_reg  <= pos_next;
                crc_reg  <= crc_next;
                rcrc_reg <= rcrc_next;
                pay_reg  <= pay_next;
                ever_reg <= ever_next;
                age_reg  <= age_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            rq_mem_reg[wr_ptr_reg] <= res_new;
        end
    end

    `UCRC_ASSERT_ALW(a_pos_range, clk, rst_n, pos_reg <= ucrc_pkg::POS_TAIL)
    `UCRC_ASSERT_IMP(a_ok_online, clk, rst_n, proc && res_new.frame_ok, res_new.online)
    `UCRC_ASSERT_NXT(a_ok_age, clk, rst_n, proc && res_new.frame_ok, ever_reg && (age_reg == '0) && (pos_reg == ucrc_pkg::POS_HUNT))
    `UCRC_ASSERT_IMP(a_no_write_full, clk, rst_n, count_reg == ucrc_pkg::QUEUE_CW'(ucrc_pkg::QUEUE_DEPTH) && !rd_en, !proc)

endmodule
